// ===== rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and the operator precedence table of the
// infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 36;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    localparam logic [1:0] RANK_OTHER = 2'd0;
    localparam logic [1:0] RANK_ADD   = 2'd1;
    localparam logic [1:0] RANK_MUL   = 2'd2;
    localparam logic [1:0] RANK_POW   = 2'd3;

    // one emitted result
    typedef struct packed {
        logic       error;
        logic       last;
        logic       has_char;
        logic [7:0] out_char;
    } itp_res_t;

    typedef struct packed {
        logic push;
        logic pop;
    } itp_stk_cmd_t;

    typedef struct packed {
        logic [7:0] top;
        logic       empty;
        logic       full;
        logic       single;
    } itp_stk_stat_t;

    // unknown characters rank lowest, below + and -
    function automatic logic [1:0] prec_rank(input logic [7:0] c);
        logic [1:0] r;
        case (c)
            CH_CARET:          r = RANK_POW;
            CH_STAR, CH_SLASH: r = RANK_MUL;
            CH_PLUS, CH_MINUS: r = RANK_ADD;
            default:           r = RANK_OTHER;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/itp_stack.sv =====
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack: register file with a fill count, push and pop by command.
// ----------------------------------------------------------------------------
module itp_stack #(
    parameter int DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  itp_pkg::itp_stk_cmd_t cmd,
    input  logic [7:0]            wdata,
    output itp_pkg::itp_stk_stat_t stat
);
    import itp_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] top_pos;
    logic             full;
    logic             empty;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign top_pos = count_reg - CNT_W'(1);

    always_comb begin
        count_next = count_reg;
        if (cmd.push && !full) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop && !empty) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && !full) begin
            mem[count_reg[IDX_W-1:0]] <= wdata;
        end
    end

    assign stat.top    = empty ? CH_NUL : mem[top_pos[IDX_W-1:0]];
    assign stat.empty  = empty;
    assign stat.full   = full;
    assign stat.single = (count_reg == CNT_W'(1));

endmodule

// ===== rtl/itp_ctrl.sv =====
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer: decodes each character and drives the stack and the precedence
// compare one step per cycle unless output stalls; one result per cycle at most.
// ----------------------------------------------------------------------------
module itp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_char,
    input  logic                   in_end,
    input  logic                   out_free,
    output logic                   emit_valid,
    output itp_pkg::itp_res_t      emit_res,
    output itp_pkg::itp_stk_cmd_t  stk_cmd,
    input  itp_pkg::itp_stk_stat_t stk_stat
);
    import itp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RPAREN,
        ST_RPAREN_SP,
        ST_OP,
        ST_OP_SP,
        ST_END,
        ST_FLUSH,
        ST_FLUSH_SP
    } state_t;

    state_t               state_reg, state_next;
    logic [7:0]           ch_reg, ch_next;
    logic                 end_reg, end_next;
    logic                 in_number_reg, in_number_next;
    logic                 error_reg, error_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;

    logic       capped;
    logic       emit_ok;
    logic       emit_req;
    logic       nat_last;
    logic       emit_has;
    logic [7:0] emit_char;

    // past the result limit emissions are dropped and never stall
    assign capped  = (cnt_reg >= RES_CNT_W'(MAX_RESULTS));
    assign emit_ok = out_free || capped;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        end_next       = end_reg;
        in_number_next = in_number_reg;
        error_next     = error_reg;
        emit_req       = 1'b0;
        nat_last       = 1'b0;
        emit_has       = 1'b1;
        emit_char      = CH_SPACE;
        stk_cmd        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    ch_next    = in_char;
                    end_next   = in_end;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (in_number_reg) begin
                    if (emit_ok) begin
                        emit_req   = 1'b1;
                        emit_char  = ch_reg;
                        state_next = ST_END;
                        if (ch_reg == CH_SPACE) begin
                            in_number_next = 1'b0;
                            nat_last       = stk_stat.empty;
                        end
                    end
                end else if (ch_reg == CH_SPACE) begin
                    state_next = ST_END;
                end else if (ch_reg inside {[CH_ZERO:CH_NINE]}) begin
                    if (emit_ok) begin
                        emit_req       = 1'b1;
                        emit_char      = ch_reg;
                        in_number_next = 1'b1;
                        state_next     = ST_END;
                    end
                end else if (ch_reg == CH_LPAREN) begin
                    stk_cmd.push = 1'b1;
                    if (stk_stat.full) begin
                        error_next = 1'b1;
                    end
                    state_next = ST_END;
                end else if (ch_reg == CH_RPAREN) begin
                    state_next = ST_RPAREN;
                end else begin
                    state_next = ST_OP;
                end
            end
            ST_RPAREN: begin
                if (stk_stat.empty) begin
                    error_next = 1'b1;
                    state_next = ST_END;
                end else if (stk_stat.top == CH_LPAREN) begin
                    stk_cmd.pop = 1'b1;
                    state_next  = ST_END;
                end else if (emit_ok) begin
                    emit_req    = 1'b1;
                    emit_char   = stk_stat.top;
                    stk_cmd.pop = 1'b1;
                    state_next  = ST_RPAREN_SP;
                end
            end
            ST_RPAREN_SP: begin
                if (emit_ok) begin
                    emit_req   = 1'b1;
                    // final only when the stack ends up empty after the match
                    nat_last   = stk_stat.empty ||
                                 (stk_stat.single && stk_stat.top == CH_LPAREN);
                    state_next = ST_RPAREN;
                end
            end
            ST_OP: begin
                if (!stk_stat.empty && prec_rank(ch_reg) <= prec_rank(stk_stat.top)) begin
                    if (emit_ok) begin
                        emit_req    = 1'b1;
                        emit_char   = stk_stat.top;
                        stk_cmd.pop = 1'b1;
                        state_next  = ST_OP_SP;
                    end
                end else begin
                    stk_cmd.push = 1'b1;
                    if (stk_stat.full) begin
                        error_next = 1'b1;
                    end
                    state_next = ST_END;
                end
            end
            ST_OP_SP: begin
                if (emit_ok) begin
                    emit_req   = 1'b1;
                    state_next = ST_OP;
                end
            end
            ST_END: begin
                if (!end_reg) begin
                    state_next = ST_IDLE;
                end else if (in_number_reg) begin
                    if (emit_ok) begin
                        emit_req       = 1'b1;
                        nat_last       = stk_stat.empty;
                        in_number_next = 1'b0;
                        state_next     = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!stk_stat.empty) begin
                    if (emit_ok) begin
                        emit_req    = 1'b1;
                        emit_char   = stk_stat.top;
                        stk_cmd.pop = 1'b1;
                        state_next  = ST_FLUSH_SP;
                    end
                end else if (cnt_reg == '0) begin
                    // nothing emitted for the expression: marker only
                    if (out_free) begin
                        emit_req   = 1'b1;
                        emit_has   = 1'b0;
                        emit_char  = CH_NUL;
                        nat_last   = 1'b1;
                        error_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end else begin
                    error_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_SP: begin
                if (emit_ok) begin
                    emit_req   = 1'b1;
                    nat_last   = stk_stat.empty;
                    state_next = ST_FLUSH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign emit_valid        = emit_req && !capped;
    assign emit_res.out_char = emit_char;
    assign emit_res.has_char = emit_has;
    assign emit_res.error    = error_reg;
    assign emit_res.last     = end_reg &&
                               (nat_last || cnt_reg == RES_CNT_W'(MAX_RESULTS - 1));

    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == ST_IDLE) begin
            cnt_next = '0;
        end else if (emit_valid) begin
            cnt_next = cnt_reg + RES_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_number_reg <= 1'b0;
            error_reg     <= 1'b0;
            cnt_reg       <= '0;
            end_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_number_reg <= in_number_next;
            error_reg     <= error_next;
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
        end
        ch_reg <= ch_next;
    end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
//  channel   dir  item
//  s_*       in   one infix character, tlast on the last of the expression
//  m_*       out  one postfix character or an end marker, tlast on the final one
//
//  A digit, a space or '(' passes decode and end; an operator or ')' adds a
//  compare or match step, and the end of the expression adds the flush.
//  Every stack entry emitted adds a character step, then a space step.
//  A result waits in the output register; while it is not taken and another
//  is due, the sequencer holds. s_tready is high only between items.
//  aresetn is synchronous and clears the stack, number mode and the error flag.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [8] error, [15:9] zero
    output logic        m_tuser,   // [0] has_char
    output logic        m_tlast
);
    import itp_pkg::*;

    itp_stk_cmd_t  stk_cmd;
    itp_stk_stat_t stk_stat;
    itp_res_t      emit_res;
    logic          emit_valid;
    logic          out_free;
    logic [7:0]    s_tdata_hold;

    logic     m_valid_reg;
    itp_res_t res_reg;

    itp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .wdata   (s_tdata_hold),
        .stat    (stk_stat)
    );

    itp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_end     (s_tlast),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit_res   (emit_res),
        .stk_cmd    (stk_cmd),
        .stk_stat   (stk_stat)
    );

    // character being worked on, pushed by the sequencer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s_tdata_hold <= s_tdata;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit_valid) begin
            res_reg <= emit_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, res_reg.error, res_reg.out_char};
    assign m_tuser  = res_reg.has_char;
    assign m_tlast  = res_reg.last;

endmodule
